// ===== rtl/core/spq_pkg.sv =====
package spq_pkg;

    // Default sizes of the queue.
    localparam int DEPTH_DEF    = 16;
    localparam int PRI_BITS_DEF = 8;
    localparam int TAG_BITS_DEF = 32;

    // Operation carried by an input beat.
    typedef enum logic {
        FUNC_ENQ = 1'b0,
        FUNC_DEQ = 1'b1
    } t_func;

    // Status returned with every result beat.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Operation broadcast to every cell of the chain at once.
    typedef struct packed {
        logic enq;
        logic deq;
    } t_cell_ctrl;

    // Where a cell stands relative to the live entries.
    typedef struct packed {
        logic occ;   // the cell holds a live entry
        logic tail;  // the cell is the first free slot
    } t_cell_pos;

endpackage

// ===== rtl/core/spq_cell.sv =====
module spq_cell #(
    parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF,
    parameter int PRI_BITS = spq_pkg::PRI_BITS_DEF
) (
    input  logic                  i_clk,
    input  spq_pkg::t_cell_ctrl   i_ctrl,
    input  spq_pkg::t_cell_pos    i_pos,
    input  logic [TAG_BITS-1:0]   i_new_tag,
    input  logic [PRI_BITS-1:0]   i_new_pri,
    input  logic                  i_prev_shift,
    input  logic [TAG_BITS-1:0]   i_prev_tag,
    input  logic [PRI_BITS-1:0]   i_prev_pri,
    input  logic [TAG_BITS-1:0]   i_next_tag,
    input  logic [PRI_BITS-1:0]   i_next_pri,
    output logic                  o_greater,
    output logic [TAG_BITS-1:0]   o_tag,
    output logic [PRI_BITS-1:0]   o_pri
);

    logic [TAG_BITS-1:0] r_tag;
    logic [PRI_BITS-1:0] r_pri;
    logic [TAG_BITS-1:0] n_tag;
    logic [PRI_BITS-1:0] n_pri;

    // A live entry strictly greater than the newcomer moves back one slot;
    // equal values stay ahead, which keeps arrival order among equals.
    assign o_greater = i_pos.occ && (r_pri > i_new_pri);

    always_comb begin
        n_tag = r_tag;
        n_pri = r_pri;
        if (i_ctrl.enq) begin
            if (i_prev_shift) begin
                n_tag = i_prev_tag;
                n_pri = i_prev_pri;
            end else if (o_greater || i_pos.tail) begin
                n_tag = i_new_tag;
                n_pri = i_new_pri;
            end
        end else if (i_ctrl.deq) begin
            n_tag = i_next_tag;
            n_pri = i_next_pri;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag <= n_tag;
        r_pri <= n_pri;
    end

    assign o_tag = r_tag;
    assign o_pri = r_pri;

endmodule

// ===== rtl/core/sorted_priority_queue_top.sv =====
// Sorted priority queue of up to DEPTH entries, each a tag and a priority.
// Input channel: i_in_valid / o_in_stall carry one beat with i_func
// (enqueue or dequeue), i_entry_tag and i_entry_priority. A beat is taken
// at a rising edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid / i_out_stall carry one result beat per input
// beat: o_status (ok, full, empty), o_served_tag and o_served_priority (the
// removed entry on a successful dequeue, else zero) and o_occupancy.
// The result is registered at the edge that takes the beat. Throughput is
// one beat per cycle while the receiver does not stall, set by the cell
// chain, where every cell compares its priority with the newcomer in
// parallel and takes data from a neighbor in the same cycle.
// When the receiver stalls, the result register holds its beat and
// o_in_stall rises, so no further beat enters until the result is taken.
// Reset (synchronous, active low) empties the queue and drops any pending
// result; no clearing pass is needed because only live slots are read.
module sorted_priority_queue_top #(
    parameter int DEPTH    = spq_pkg::DEPTH_DEF,
    parameter int PRI_BITS = spq_pkg::PRI_BITS_DEF,
    parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF,
    localparam int CNT_W   = $clog2(DEPTH + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_func,
    input  logic [TAG_BITS-1:0] i_entry_tag,
    input  logic [PRI_BITS-1:0] i_entry_priority,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_status,
    output logic [TAG_BITS-1:0] o_served_tag,
    output logic [PRI_BITS-1:0] o_served_priority,
    output logic [CNT_W-1:0]    o_occupancy
);

    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_out_valid;
    logic                n_out_valid;
    spq_pkg::t_status    r_status;
    spq_pkg::t_status    n_status;
    logic [TAG_BITS-1:0] r_tag;
    logic [TAG_BITS-1:0] n_tag;
    logic [PRI_BITS-1:0] r_pri;
    logic [PRI_BITS-1:0] n_pri;

    logic                accept;
    logic                is_deq;
    logic                full;
    logic                empty;
    spq_pkg::t_cell_ctrl ctrl;

    logic [DEPTH-1:0]    greater;
    logic [TAG_BITS-1:0] cell_tag [DEPTH];
    logic [PRI_BITS-1:0] cell_pri [DEPTH];

    // The input side waits only while a finished result is held back.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign is_deq     = (i_func == spq_pkg::FUNC_DEQ);
    assign full       = (r_count == CNT_W'(DEPTH));
    assign empty      = (r_count == '0);

    // A dropped enqueue or an empty dequeue leaves the chain untouched.
    assign ctrl.enq = accept && !is_deq && !full;
    assign ctrl.deq = accept && is_deq && !empty;

    // Cell 0 is the front of the queue. On enqueue each cell either keeps
    // its entry, takes the newcomer, or takes its front neighbor's entry;
    // on dequeue every cell takes its back neighbor's entry.
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        spq_pkg::t_cell_pos  pos;
        logic                prev_shift;
        logic [TAG_BITS-1:0] prev_tag;
        logic [PRI_BITS-1:0] prev_pri;
        logic [TAG_BITS-1:0] next_tag;
        logic [PRI_BITS-1:0] next_pri;

        assign pos.occ  = (CNT_W'(k) < r_count);
        assign pos.tail = (CNT_W'(k) == r_count);

        if (k == 0) begin : g_front
            assign prev_shift = 1'b0;
            assign prev_tag   = '0;
            assign prev_pri   = '0;
        end else begin : g_mid
            assign prev_shift = greater[k-1];
            assign prev_tag   = cell_tag[k-1];
            assign prev_pri   = cell_pri[k-1];
        end

        if (k == DEPTH - 1) begin : g_back
            assign next_tag = '0;
            assign next_pri = '0;
        end else begin : g_inner
            assign next_tag = cell_tag[k+1];
            assign next_pri = cell_pri[k+1];
        end

        spq_cell #(
            .TAG_BITS (TAG_BITS),
            .PRI_BITS (PRI_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (ctrl),
            .i_pos        (pos),
            .i_new_tag    (i_entry_tag),
            .i_new_pri    (i_entry_priority),
            .i_prev_shift (prev_shift),
            .i_prev_tag   (prev_tag),
            .i_prev_pri   (prev_pri),
            .i_next_tag   (next_tag),
            .i_next_pri   (next_pri),
            .o_greater    (greater[k]),
            .o_tag        (cell_tag[k]),
            .o_pri        (cell_pri[k])
        );
    end

    // Count update and the result register.
    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_tag       = r_tag;
        n_pri       = r_pri;
        if (ctrl.enq) begin
            n_count = r_count + CNT_W'(1);
        end else if (ctrl.deq) begin
            n_count = r_count - CNT_W'(1);
        end
        if (accept) begin
            n_out_valid = 1'b1;
            n_tag       = '0;
            n_pri       = '0;
            if (ctrl.enq || ctrl.deq) begin
                n_status = spq_pkg::ST_OK;
            end else if (is_deq) begin
                n_status = spq_pkg::ST_EMPTY;
            end else begin
                n_status = spq_pkg::ST_FULL;
            end
            if (ctrl.deq) begin
                n_tag = cell_tag[0];
                n_pri = cell_pri[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_status <= n_status;
        r_tag    <= n_tag;
        r_pri    <= n_pri;
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_served_tag      = r_tag;
    assign o_served_priority = r_pri;
    // The count register already holds the occupancy after the held beat,
    // since no beat enters while a result waits.
    assign o_occupancy       = r_count;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count exceeds capacity");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && is_deq && empty |=> r_status == spq_pkg::ST_EMPTY && r_count == '0)
        else $error("dequeue from empty queue not reported as empty");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !is_deq && full |=> r_status == spq_pkg::ST_FULL && $stable(r_count))
        else $error("enqueue into full queue not dropped");

    a_front_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count >= CNT_W'(2) |-> cell_pri[0] <= cell_pri[1])
        else $error("front entries out of priority order");

    a_served_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.deq |=> r_tag == $past(cell_tag[0]) && r_pri == $past(cell_pri[0]))
        else $error("dequeue did not return the front entry");
`endif

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Sizes follow the package defaults that the block is built with.
    localparam int DEPTH    = spq_pkg::DEPTH_DEF;
    localparam int PRI_W    = spq_pkg::PRI_BITS_DEF;
    localparam int TAG_W    = spq_pkg::TAG_BITS_DEF;
    localparam int CNT_W    = $clog2(DEPTH + 1);

    // The receiver holds off this long once, so that the result register
    // stays full and the block has to stall its input side.
    localparam int RX_HOLD_CYCLES = 150;

    // The slowest correct run is roughly 1600 beats, each of which may see a
    // long sender gap, a long result stall and a long free run on the
    // receiver, plus the hold-off. The limit sits well above the sum of
    // these.
    localparam int CYCLE_LIMIT = 900_000;

    // One entry of the queue as the testbench keeps it.
    typedef struct {
        logic [TAG_W-1:0] tag;
        logic [PRI_W-1:0] prio;
    } t_slot;

    // One result beat as the testbench expects to see it.
    typedef struct {
        spq_pkg::t_status status;
        logic [TAG_W-1:0] tag;
        logic [PRI_W-1:0] prio;
        logic [CNT_W-1:0] occ;
    } t_result;

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               i_in_valid       = 1'b0;
    logic               i_func           = spq_pkg::FUNC_ENQ;
    logic [TAG_W-1:0]   i_entry_tag      = '0;
    logic [PRI_W-1:0]   i_entry_priority = '0;
    logic               i_out_stall      = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [1:0]         o_status;
    logic [TAG_W-1:0]   o_served_tag;
    logic [PRI_W-1:0]   o_served_priority;
    logic [CNT_W-1:0]   o_occupancy;

    // Shadow copy of the queue contents, front entry at index 0, and the
    // results that accepted beats still owe us, oldest first.
    t_slot       shadow_slots[$];
    t_result     pending_results[$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // Test control: the quiet flags switch off random idling on one side,
    // and the hold request asks the receiver for one long stall. The
    // receiver raises the holding flag while that long stall runs.
    bit          tx_quiet    = 1'b0;
    bit          rx_quiet    = 1'b0;
    bit          rx_hold_req = 1'b0;
    bit          rx_holding  = 1'b0;

    sorted_priority_queue_top u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_func            (i_func),
        .i_entry_tag       (i_entry_tag),
        .i_entry_priority  (i_entry_priority),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_served_tag      (o_served_tag),
        .o_served_priority (o_served_priority),
        .o_occupancy       (o_occupancy)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Runaway guard: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Idle length for a sender gap or a receiver stall: mostly none, often a
    // short one, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // How long the receiver stays ready between stalls.
    function automatic int unsigned ready_len();
        if ($urandom_range(0, 99) < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 60);
    endfunction

    // Works out what the block must return for one accepted beat and moves
    // the shadow queue along. An enqueue goes behind every entry of equal or
    // lower priority value, which keeps equal priorities in arrival order.
    function automatic t_result predict_service(spq_pkg::t_func op,
                                                logic [TAG_W-1:0] tag,
                                                logic [PRI_W-1:0] prio);
        t_result res;
        t_slot   ent;
        int      pos;
        res.status = spq_pkg::ST_OK;
        res.tag    = '0;
        res.prio   = '0;
        if (op == spq_pkg::FUNC_ENQ) begin
            if (shadow_slots.size() >= DEPTH) begin
                res.status = spq_pkg::ST_FULL;
            end else begin
                ent.tag  = tag;
                ent.prio = prio;
                pos = shadow_slots.size();
                while (pos > 0 && shadow_slots[pos-1].prio > prio) pos--;
                shadow_slots.insert(pos, ent);
            end
        end else begin
            if (shadow_slots.size() == 0) begin
                res.status = spq_pkg::ST_EMPTY;
            end else begin
                res.tag  = shadow_slots[0].tag;
                res.prio = shadow_slots[0].prio;
                void'(shadow_slots.pop_front());
            end
        end
        res.occ = CNT_W'(shadow_slots.size());
        return res;
    endfunction

    task automatic flag_mismatch(string field, logic [TAG_W-1:0] got,
                                 logic [TAG_W-1:0] want);
        $display("ERROR at cycle %0d: %s is 0x%0h, should be 0x%0h",
                 cycle_count, field, got, want);
        mismatch_count++;
    endtask

    // Offers one beat and returns at the edge that takes it. The gap that
    // follows is spent here, so a beat sent right after keeps valid high
    // without dropping it in between.
    task automatic send_beat(spq_pkg::t_func op, logic [TAG_W-1:0] tag,
                             logic [PRI_W-1:0] prio);
        int unsigned gap;
        i_in_valid       <= 1'b1;
        i_func           <= op;
        i_entry_tag      <= tag;
        i_entry_priority <= prio;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        pending_results.push_back(predict_service(op, tag, prio));
        gap = tx_quiet ? 0 : idle_len();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stops offering beats and waits until every owed result has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: alternates stalls and ready stretches of random length. A
    // hold request from a test turns the next stall into one long stretch.
    initial begin
        int unsigned stall_cycles;
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                stall_cycles = RX_HOLD_CYCLES;
                rx_holding   = 1'b1;
            end else begin
                stall_cycles = rx_quiet ? 0 : idle_len();
            end
            if (stall_cycles != 0) begin
                i_out_stall <= 1'b1;
                repeat (stall_cycles) @(posedge i_clk);
                rx_hold_req = 1'b0;
                rx_holding  = 1'b0;
            end
            i_out_stall <= 1'b0;
            repeat (rx_quiet ? 1 : ready_len()) @(posedge i_clk);
        end
    end

    // Every result beat taken at an edge is matched against the oldest
    // expectation, field by field.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("result beat with nothing owed, status",
                              TAG_W'(o_status), '0);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    flag_mismatch("status", TAG_W'(o_status), TAG_W'(want.status));
                if (o_served_tag !== want.tag)
                    flag_mismatch("served tag", o_served_tag, want.tag);
                if (o_served_priority !== want.prio)
                    flag_mismatch("served priority", TAG_W'(o_served_priority),
                                  TAG_W'(want.prio));
                if (o_occupancy !== want.occ)
                    flag_mismatch("occupancy", TAG_W'(o_occupancy), TAG_W'(want.occ));
            end
        end
    end

    // A dequeue straight after reset finds the queue empty.
    task automatic test_empty_dequeue();
        send_beat(spq_pkg::FUNC_DEQ, '1, '1);
    endtask

    // Fills the queue with extreme tags and priorities and several ties,
    // pushes one enqueue past capacity, then serves the front few entries,
    // which must come out lowest value first and oldest first among ties.
    task automatic test_fill_overflow();
        logic [PRI_W-1:0] fill_prios [DEPTH] = '{
            8'hFF, 8'h00, 8'h05, 8'h05, 8'h00, 8'h80, 8'h05, 8'hFF,
            8'h01, 8'h7F, 8'h00, 8'h05, 8'hFE, 8'h80, 8'h02, 8'h05};
        logic [TAG_W-1:0] tag;
        for (int k = 0; k < DEPTH; k++) begin
            tag = (k == 1) ? '1 : TAG_W'(k * 32'h0101_0101);
            send_beat(spq_pkg::FUNC_ENQ, tag, fill_prios[k]);
        end
        send_beat(spq_pkg::FUNC_ENQ, 32'hDEAD_BEEF, 8'h00);
        repeat (4) send_beat(spq_pkg::FUNC_DEQ, TAG_W'($urandom), PRI_W'($urandom));
        wait_drained();
    endtask

    // Bursts that lean toward filling or toward emptying, so that both the
    // full and the empty corner are hit again and again. Priorities are
    // drawn from the whole range, from a tiny range full of ties, from the
    // extremes only, or from a cluster around a random base.
    task automatic test_random_traffic(int unsigned beats);
        int unsigned      sent;
        int unsigned      burst;
        int unsigned      mode;
        int unsigned      base;
        bit               lean_enq;
        spq_pkg::t_func   op;
        logic [PRI_W-1:0] prio;
        sent = 0;
        while (sent < beats) begin
            burst    = $urandom_range(4, 40);
            lean_enq = 1'($urandom_range(0, 1));
            mode     = $urandom_range(0, 3);
            base     = $urandom_range(0, 250);
            for (int k = 0; k < burst; k++) begin
                if ($urandom_range(0, 99) < 80)
                    op = lean_enq ? spq_pkg::FUNC_ENQ : spq_pkg::FUNC_DEQ;
                else
                    op = lean_enq ? spq_pkg::FUNC_DEQ : spq_pkg::FUNC_ENQ;
                case (mode)
                    0: prio = PRI_W'($urandom);
                    1: prio = PRI_W'($urandom_range(0, 3));
                    2: begin
                        case ($urandom_range(0, 3))
                            0: prio = 8'h00;
                            1: prio = 8'h01;
                            2: prio = 8'hFE;
                            default: prio = 8'hFF;
                        endcase
                    end
                    default: prio = PRI_W'(base + $urandom_range(0, 5));
                endcase
                send_beat(op, TAG_W'($urandom), prio);
                sent++;
            end
        end
        wait_drained();
    endtask

    // No idling on either side: one beat per cycle in both directions.
    task automatic test_back_to_back();
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        for (int k = 0; k < 100; k++) begin
            send_beat(($urandom_range(0, 99) < 55) ? spq_pkg::FUNC_ENQ : spq_pkg::FUNC_DEQ,
                      TAG_W'($urandom), PRI_W'($urandom_range(0, 7)));
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        wait_drained();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering beats, so the result register stays full and the input
    // side must stall without losing or repeating a beat. The beats start
    // only once the long stall is under way.
    task automatic test_result_hold();
        rx_hold_req = 1'b1;
        tx_quiet    = 1'b1;
        wait (rx_holding);
        for (int k = 0; k < 40; k++) begin
            send_beat(($urandom_range(0, 99) < 70) ? spq_pkg::FUNC_ENQ : spq_pkg::FUNC_DEQ,
                      TAG_W'($urandom), PRI_W'($urandom));
        end
        tx_quiet = 1'b0;
        wait_drained();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_dequeue();
        test_fill_overflow();
        test_result_hold();
        test_random_traffic(1350);
        test_back_to_back();
        test_random_traffic(100);

        // Each result is registered at the edge that takes its beat; the spare
        // edges below catch any stray beat that should not be there.
        repeat (5) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
